// ===== src/seven_segment_value_formatter_macros.svh =====
// Assertion macros shared by the checker of the seven-segment value formatter.
// No dependencies; included by the files that hold concurrent assertions.
`ifndef SEVEN_SEGMENT_VALUE_FORMATTER_MACROS_SVH
`define SEVEN_SEGMENT_VALUE_FORMATTER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SSVF_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("seven segment formatter: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define SSVF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("seven segment formatter: next-cycle check failed");

`endif

// ===== src/ssvf_pkg.sv =====
// Package of the seven-segment value formatter: item type, mode codes and glyph table.
// No dependencies; used by the top level, the decoder and the testbench.
`timescale 1ns / 1ps

package ssvf_pkg;

	localparam logic [1:0] MODE_UNSIGNED = 2'd0;
	localparam logic [1:0] MODE_SIGNED   = 2'd1;
	localparam logic [1:0] MODE_HEX      = 2'd2;
	localparam logic [1:0] MODE_BINARY   = 2'd3;

	localparam logic [1:0] POS_LEFT   = 2'd0;
	localparam logic [1:0] POS_SECOND = 2'd1;
	localparam logic [1:0] POS_THIRD  = 2'd2;
	localparam logic [1:0] POS_RIGHT  = 2'd3;

	localparam logic [7:0] SEG_BLANK  = 8'h00;
	localparam logic [7:0] SEG_MINUS  = 8'h40;
	localparam logic [7:0] SEG_HEX_H  = 8'h74;
	localparam logic [7:0] SEG_E      = 8'h10;
	localparam logic [7:0] SEG_C      = 8'h04;
	localparam logic [7:0] MASK_RESET = 8'hFF;

	typedef struct packed {
		logic [1:0] display_mode;
		logic [1:0] digit_position;
		logic [7:0] shown_value;
	} ssvf_item_t;

	// Segment pattern of a hex digit, segment a in bit 0.
	function automatic logic [7:0] glyph(input logic [3:0] nibble);
		logic [7:0] seg;
		unique case (nibble)
			4'h0: seg = 8'h3f;
			4'h1: seg = 8'h06;
			4'h2: seg = 8'h5b;
			4'h3: seg = 8'h4f;
			4'h4: seg = 8'h66;
			4'h5: seg = 8'h6d;
			4'h6: seg = 8'h7d;
			4'h7: seg = 8'h07;
			4'h8: seg = 8'h7f;
			4'h9: seg = 8'h6f;
			4'ha: seg = 8'h77;
			4'hb: seg = 8'h7c;
			4'hc: seg = 8'h39;
			4'hd: seg = 8'h5e;
			4'he: seg = 8'h79;
			default: seg = 8'h71;
		endcase
		return seg;
	endfunction

endpackage

// ===== src/seven_segment_value_formatter.sv =====
// Top level of the seven-segment value formatter: input register, decode, result register.
// Depends on ssvf_pkg and ssvf_digit_decode.
`timescale 1ns / 1ps

// The block turns one (display_mode, digit_position, shown_value) item into the
// segment pattern of that display digit, XORed with the invert mask.
// Input channel: in_valid / in_ready with fields display_mode, digit_position and
// shown_value; a transfer happens at a rising edge where both are high.
// Output channel: out_valid / out_ready with field segment_pattern.
// The invert mask is written through cfg_we / cfg_wdata, with no read-back; it
// should only be changed while no item is in flight.
// After an input transfer the item passes the input register, is then decoded
// into the result register, and out_valid rises to offer it.
// Throughput is one item per cycle unless stalled; each stage holds one item
// and advances whenever the stage after it is empty or draining in the same cycle.
// When the receiver stalls, the result register holds its pattern, the input
// register fills behind it, and in_ready drops only once both stages are full.
// Reset empties both stages and sets the invert mask to all ones, which suits a
// common-anode display.
module seven_segment_value_formatter (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [7:0] cfg_wdata,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [1:0] display_mode,
	input  logic [1:0] digit_position,
	input  logic [7:0] shown_value,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] segment_pattern
);

	logic [7:0]           invert_mask_q;
	logic                 valid_s1;
	ssvf_pkg::ssvf_item_t item_s1;
	logic                 valid_s2;
	logic [7:0]           pattern_s2;
	logic [7:0]           raw_pattern;
	logic                 s2_ready;
	logic                 s1_ready;

	assign s2_ready = !valid_s2 || out_ready;
	assign s1_ready = !valid_s1 || s2_ready;
	assign in_ready = s1_ready;

	// Invert mask register, written at any cycle the enable is high.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			invert_mask_q <= ssvf_pkg::MASK_RESET;
		end else if (cfg_we) begin
			invert_mask_q <= cfg_wdata;
		end
	end

	// Stage 1: capture the accepted item.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s1_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_ready && in_valid) begin
			item_s1.display_mode   <= display_mode;
			item_s1.digit_position <= digit_position;
			item_s1.shown_value    <= shown_value;
		end
	end

	ssvf_digit_decode u_decode (
		.item        (item_s1),
		.raw_pattern (raw_pattern)
	);

	// Stage 2: the result register, which holds while the receiver stalls.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s2_ready) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_ready && valid_s1) begin
			pattern_s2 <= raw_pattern ^ invert_mask_q;
		end
	end

	assign out_valid       = valid_s2;
	assign segment_pattern = pattern_s2;

endmodule

// ===== src/ssvf_digit_decode.sv =====
// Combinational decode of one registered item into the raw segment pattern.
// Depends on ssvf_pkg.
`timescale 1ns / 1ps

module ssvf_digit_decode (
	input  ssvf_pkg::ssvf_item_t item,
	output logic [7:0]           raw_pattern
);

	logic        negative;
	logic [7:0]  magnitude;
	logic [7:0]  dec_src;
	logic [1:0]  hundreds;
	logic [7:0]  hund_sub;
	logic [6:0]  rem;
	logic [14:0] tens_prod;
	logic [3:0]  tens;
	logic [6:0]  tens_x10;
	logic [3:0]  units;
	logic [7:0]  dec_seg;
	logic [1:0]  pair;
	logic [7:0]  bin_seg;

	always_comb begin
		negative  = item.shown_value[7];
		magnitude = negative ? (~item.shown_value + 8'd1) : item.shown_value;
		dec_src   = (item.display_mode == ssvf_pkg::MODE_SIGNED) ? magnitude : item.shown_value;

		// Split into decimal digits; the tens use a reciprocal multiply valid below 100.
		if (dec_src >= 8'd200) begin
			hundreds = 2'd2;
			hund_sub = 8'd200;
		end else if (dec_src >= 8'd100) begin
			hundreds = 2'd1;
			hund_sub = 8'd100;
		end else begin
			hundreds = 2'd0;
			hund_sub = 8'd0;
		end
		rem       = 7'(dec_src - hund_sub);
		tens_prod = 15'(rem) * 15'd205;
		tens      = tens_prod[14:11];
		tens_x10  = 7'({tens, 3'b000}) + 7'({tens, 1'b0});
		units     = 4'(rem - tens_x10);

		unique case (item.digit_position)
			ssvf_pkg::POS_LEFT:   dec_seg = ssvf_pkg::SEG_BLANK;
			ssvf_pkg::POS_SECOND: dec_seg = ssvf_pkg::glyph({2'b00, hundreds});
			ssvf_pkg::POS_THIRD:  dec_seg = ssvf_pkg::glyph(tens);
			default:              dec_seg = ssvf_pkg::glyph(units);
		endcase

		// Binary mode shows the most significant bit pair on the leftmost digit.
		unique case (item.digit_position)
			ssvf_pkg::POS_LEFT:   pair = item.shown_value[7:6];
			ssvf_pkg::POS_SECOND: pair = item.shown_value[5:4];
			ssvf_pkg::POS_THIRD:  pair = item.shown_value[3:2];
			default:              pair = item.shown_value[1:0];
		endcase
		bin_seg = (pair[1] ? ssvf_pkg::SEG_E : ssvf_pkg::SEG_BLANK)
			| (pair[0] ? ssvf_pkg::SEG_C : ssvf_pkg::SEG_BLANK);

		unique case (item.display_mode)
			ssvf_pkg::MODE_UNSIGNED: raw_pattern = dec_seg;
			ssvf_pkg::MODE_SIGNED: begin
				if (item.digit_position == ssvf_pkg::POS_LEFT) begin
					raw_pattern = negative ? ssvf_pkg::SEG_MINUS : ssvf_pkg::SEG_BLANK;
				end else begin
					raw_pattern = dec_seg;
				end
			end
			ssvf_pkg::MODE_HEX: begin
				unique case (item.digit_position)
					ssvf_pkg::POS_LEFT:   raw_pattern = ssvf_pkg::glyph(4'h0);
					ssvf_pkg::POS_SECOND: raw_pattern = ssvf_pkg::SEG_HEX_H;
					ssvf_pkg::POS_THIRD:  raw_pattern = ssvf_pkg::glyph(item.shown_value[7:4]);
					default:              raw_pattern = ssvf_pkg::glyph(item.shown_value[3:0]);
				endcase
			end
			default: raw_pattern = bin_seg;
		endcase
	end

endmodule

// ===== src/ssvf_checker.sv =====
// Port-level checker of the seven-segment value formatter, bound to the top level.
// Depends on seven_segment_value_formatter_macros.svh and seven_segment_value_formatter.
`timescale 1ns / 1ps
`include "seven_segment_value_formatter_macros.svh"

module ssvf_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       cfg_we,
	input logic [7:0] cfg_wdata,
	input logic       in_valid,
	input logic       in_ready,
	input logic [1:0] display_mode,
	input logic [1:0] digit_position,
	input logic [7:0] shown_value,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] segment_pattern
);

	// A stalled result stays offered.
	`SSVF_ASSERT_NEXT(a_out_held, clk, arst_n, out_valid && !out_ready, out_valid)

	// A stalled result keeps its pattern.
	`SSVF_ASSERT_NEXT(a_out_stable, clk, arst_n, out_valid && !out_ready, $stable(segment_pattern))

	// With the result register empty, the block always takes an item.
	`SSVF_ASSERT_NOW(a_ready_when_empty, clk, arst_n, !out_valid, in_ready)

	// The block refuses input only when the receiver is stalling a held result.
	`SSVF_ASSERT_NOW(a_backpressure_source, clk, arst_n, !in_ready, out_valid && !out_ready)

endmodule

bind seven_segment_value_formatter ssvf_checker u_ssvf_checker (.*);

// ===== test/tb_top.sv =====
// Testbench of the seven-segment value formatter: random and directed digit requests
// with a scoreboard that predicts each segment pattern. Depends on ssvf_pkg and the RTL.
`timescale 1ns / 1ps

module tb_top;

	// Number of cycles without any transfer after which the run is declared hung.
	// A correct run never comes close to this limit.
	localparam int unsigned HANG_LIMIT   = 2000;
	// Cycles to let pass once the pipeline looks empty; the block has two stages.
	localparam int unsigned SETTLE_TICKS = 4;
	localparam int unsigned PHASE_ITEMS  = 370;

	// The scoreboard keeps its own copy of the invert mask and a queue of the
	// patterns that the accepted digit requests should produce, oldest first.
	class seg_scoreboard;
		logic [7:0]  invert_mask;
		logic [7:0]  expected_patterns[$];
		logic [7:0]  digit_glyphs[16];
		int unsigned mismatches;

		function new();
			invert_mask  = ssvf_pkg::MASK_RESET;
			mismatches   = 0;
			digit_glyphs = '{8'h3f, 8'h06, 8'h5b, 8'h4f, 8'h66, 8'h6d, 8'h7d, 8'h07,
			                 8'h7f, 8'h6f, 8'h77, 8'h7c, 8'h39, 8'h5e, 8'h79, 8'h71};
		endfunction

		// Hundreds, tens or units of a magnitude up to 255; the leftmost digit is blank.
		function logic [7:0] decimal_segments(int unsigned magnitude, logic [1:0] position);
			logic [7:0] seg;
			case (position)
				ssvf_pkg::POS_SECOND: seg = digit_glyphs[(magnitude / 100) % 10];
				ssvf_pkg::POS_THIRD:  seg = digit_glyphs[(magnitude / 10) % 10];
				ssvf_pkg::POS_RIGHT:  seg = digit_glyphs[magnitude % 10];
				default:              seg = ssvf_pkg::SEG_BLANK;
			endcase
			return seg;
		endfunction

		// Segment pattern of one digit before the invert mask.
		function logic [7:0] plain_segments(logic [1:0] mode, logic [1:0] position,
		                                    logic [7:0] value);
			logic [7:0]  seg;
			logic [1:0]  bit_pair;
			int unsigned magnitude;
			seg = ssvf_pkg::SEG_BLANK;
			case (mode)
				ssvf_pkg::MODE_UNSIGNED: seg = decimal_segments(int'(value), position);
				ssvf_pkg::MODE_SIGNED: begin
					// Two's complement: -128 has magnitude 128.
					magnitude = value[7] ? 256 - int'(value) : int'(value);
					if (position == ssvf_pkg::POS_LEFT)
						seg = value[7] ? ssvf_pkg::SEG_MINUS : ssvf_pkg::SEG_BLANK;
					else
						seg = decimal_segments(magnitude, position);
				end
				ssvf_pkg::MODE_HEX: begin
					case (position)
						ssvf_pkg::POS_LEFT:   seg = digit_glyphs[0];
						ssvf_pkg::POS_SECOND: seg = ssvf_pkg::SEG_HEX_H;
						ssvf_pkg::POS_THIRD:  seg = digit_glyphs[value[7:4]];
						default:              seg = digit_glyphs[value[3:0]];
					endcase
				end
				default: begin
					// Two bits per digit, most significant pair on the leftmost digit.
					bit_pair = 2'(value >> ((3 - int'(position)) * 2));
					if (bit_pair[1]) seg = seg | ssvf_pkg::SEG_E;
					if (bit_pair[0]) seg = seg | ssvf_pkg::SEG_C;
				end
			endcase
			return seg;
		endfunction

		function void note_item(logic [1:0] mode, logic [1:0] position, logic [7:0] value);
			expected_patterns.push_back(plain_segments(mode, position, value) ^ invert_mask);
		endfunction

		function void check_pattern(logic [7:0] actual);
			logic [7:0] wanted;
			if (expected_patterns.size() == 0) begin
				$error("segment_pattern: no result expected, actual %h", actual);
				mismatches++;
			end else begin
				wanted = expected_patterns.pop_front();
				if (actual !== wanted) begin
					$error("segment_pattern: expected %h, actual %h", wanted, actual);
					mismatches++;
				end
			end
		endfunction
	endclass

	logic       clk;
	logic       arst_n;
	logic       cfg_we;
	logic [7:0] cfg_wdata;
	logic       in_valid;
	logic       in_ready;
	logic [1:0] display_mode;
	logic [1:0] digit_position;
	logic [7:0] shown_value;
	logic       out_valid;
	logic       out_ready;
	logic [7:0] segment_pattern;

	seg_scoreboard pattern_board;

	// Percentages of cycles in which the sender idles and the receiver stalls.
	int unsigned send_idle_pct;
	int unsigned recv_stall_pct;
	int unsigned quiet_cycles;

	seven_segment_value_formatter i_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_wdata      (cfg_wdata),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.display_mode   (display_mode),
		.digit_position (digit_position),
		.shown_value    (shown_value),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.segment_pattern(segment_pattern)
	);

	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// The receiver decides at every falling edge whether it takes a result at the
	// next rising edge. Ready may drop freely; only valid has to be held.
	always @(negedge clk) begin
		out_ready = ($urandom_range(99) >= recv_stall_pct);
	end

	// Transfers are observed at the rising edge, where the sampled values are the
	// ones that were stable for the preceding half period. The same process runs
	// the watchdog: every transfer resets it.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (in_valid && in_ready)
				pattern_board.note_item(display_mode, digit_position, shown_value);
			if (out_valid && out_ready)
				pattern_board.check_pattern(segment_pattern);
			if (quiet_cycles >= HANG_LIMIT) begin
				$display("FAILURE");
				$finish;
			end
		end
	end

	// Offers one digit request and returns at the rising edge where it transfers.
	// Before the request the sender may idle; while idle it scrambles the fields so
	// that the block cannot rely on them outside a transfer.
	task automatic send_digit(input logic [1:0] mode, input logic [1:0] position,
	                          input logic [7:0] value);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid       = 1'b0;
			display_mode   = 2'($urandom_range(3));
			digit_position = 2'($urandom_range(3));
			shown_value    = 8'($urandom_range(255));
			@(negedge clk);
		end
		in_valid       = 1'b1;
		display_mode   = mode;
		digit_position = position;
		shown_value    = value;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
	endtask

	// Stops offering requests and waits until every predicted pattern has come
	// out, then lets the pipeline settle so that nothing is left in flight.
	task automatic drain_results();
		@(negedge clk);
		in_valid = 1'b0;
		while (pattern_board.expected_patterns.size() != 0)
			@(negedge clk);
		repeat (SETTLE_TICKS) @(negedge clk);
	endtask

	// Writes the invert mask; the caller makes sure that the block is idle.
	task automatic write_invert_mask(input logic [7:0] mask);
		@(negedge clk);
		cfg_we    = 1'b1;
		cfg_wdata = mask;
		@(negedge clk);
		cfg_we = 1'b0;
		pattern_board.invert_mask = mask;
	endtask

	// Values weighted toward the edges: zero, all ones, the most negative and the
	// most positive signed values.
	function automatic logic [7:0] pick_value();
		logic [7:0] value;
		case ($urandom_range(7))
			0:       value = 8'h00;
			1:       value = 8'hFF;
			2:       value = 8'h80;
			3:       value = 8'h7F;
			default: value = 8'($urandom_range(255));
		endcase
		return value;
	endfunction

	task automatic run_random_phase(input int unsigned idle_pct, input int unsigned stall_pct,
	                                input logic [7:0] mask);
		send_idle_pct  = idle_pct;
		recv_stall_pct = stall_pct;
		write_invert_mask(mask);
		repeat (PHASE_ITEMS)
			send_digit(2'($urandom_range(3)), 2'($urandom_range(3)), pick_value());
		// The sender pauses here until every expected result has arrived.
		drain_results();
	endtask

	initial begin
		logic [7:0] edge_values[4];
		edge_values = '{8'h00, 8'hFF, 8'h80, 8'h7F};

		pattern_board  = new();
		arst_n         = 1'b0;
		cfg_we         = 1'b0;
		cfg_wdata      = 8'h00;
		in_valid       = 1'b0;
		display_mode   = ssvf_pkg::MODE_UNSIGNED;
		digit_position = ssvf_pkg::POS_LEFT;
		shown_value    = 8'h00;
		out_ready      = 1'b0;
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		quiet_cycles   = 0;
		repeat (3) @(negedge clk);
		arst_n = 1'b1;

		// Directed part, run with the mask left at its reset value of all ones.
		// Every mode and every digit sees each of the edge values in turn.
		for (int m = 0; m < 4; m++)
			for (int p = 0; p < 4; p++)
				send_digit(2'(m), 2'(p), edge_values[(m + p) % 4]);
		// Blank leftmost digit in unsigned mode and for a non-negative signed value.
		send_digit(ssvf_pkg::MODE_UNSIGNED, ssvf_pkg::POS_LEFT, 8'hAB);
		send_digit(ssvf_pkg::MODE_SIGNED, ssvf_pkg::POS_LEFT, 8'h00);
		// Minus one shows as 001 behind a minus sign.
		send_digit(ssvf_pkg::MODE_SIGNED, ssvf_pkg::POS_LEFT, 8'hFF);
		send_digit(ssvf_pkg::MODE_SIGNED, ssvf_pkg::POS_RIGHT, 8'hFF);
		// The most negative value shows as 128.
		send_digit(ssvf_pkg::MODE_SIGNED, ssvf_pkg::POS_SECOND, 8'h80);
		send_digit(ssvf_pkg::MODE_SIGNED, ssvf_pkg::POS_THIRD, 8'h80);
		// A hex letter in the upper nibble, and a binary pattern with mixed pairs.
		send_digit(ssvf_pkg::MODE_HEX, ssvf_pkg::POS_THIRD, 8'hC4);
		send_digit(ssvf_pkg::MODE_BINARY, ssvf_pkg::POS_SECOND, 8'h96);
		drain_results();

		// Random phases, each under its own mask: no idling, an idling sender, a slow
		// receiver, then both at once. The masks are all zeros, random, all ones, random.
		run_random_phase(0, 0, 8'h00);
		run_random_phase(47, 0, 8'($urandom_range(255)));
		run_random_phase(0, 47, ssvf_pkg::MASK_RESET);
		run_random_phase(36, 36, 8'($urandom_range(255)));

		if (pattern_board.mismatches == 0 && pattern_board.expected_patterns.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

// ===== seven_segment_value_formatter.f =====
+incdir+src
src/ssvf_pkg.sv
src/ssvf_digit_decode.sv
src/seven_segment_value_formatter.sv
src/ssvf_checker.sv
test/tb_top.sv
